### hdl/ole_pkg.sv
package ole_pkg;

    // Field widths of the command and result items
    localparam int MODE_W  = 3;
    localparam int VALUE_W = 32;
    localparam int IDX_W   = 7;
    localparam int STAT_W  = 3;
    localparam int LEN_W   = 7;

    // Command modes
    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FIND   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_HEAD   = 3'd5;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd4;

    // Cell row operation applied in the shift cycle
    typedef enum logic [1:0] {
        OP_NONE,
        OP_INS,
        OP_READ,
        OP_DEL
    } op_t;

    // Controller states
    typedef enum logic {
        S_ACCEPT,
        S_EXEC
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } ole_cmd_t;

endpackage

### hdl/ole_ctrl.sv
module ole_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output ole_pkg::ole_cmd_t cmd
);
    import ole_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // State and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_ACCEPT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Accept in one state, commit the shift once the output slot is free
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_ACCEPT: begin
                // hold ready low while reset is asserted
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_ACCEPT;
                end
            end
            default: begin
                state_next = S_ACCEPT;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

### hdl/ole_datapath.sv
module ole_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  ole_pkg::ole_cmd_t                    cmd,
    input  logic        [ole_pkg::MODE_W-1:0]    s_mode,
    input  logic signed [ole_pkg::VALUE_W-1:0]   s_value,
    input  logic        [ole_pkg::IDX_W-1:0]     s_index,
    output logic        [ole_pkg::STAT_W-1:0]    m_status,
    output logic signed [ole_pkg::VALUE_W-1:0]   m_read_value,
    output logic        [ole_pkg::LEN_W-1:0]     m_length
);
    import ole_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CW > IDX_W) ? CW : IDX_W;
    localparam int LW = (CW > LEN_W) ? CW : LEN_W;

    // Cell row and fill count
    logic signed [VALUE_W-1:0] cell_reg  [CAPACITY];
    logic signed [VALUE_W-1:0] cell_next [CAPACITY];
    logic [CW-1:0]             count_reg, count_next;

    // Compare-cycle results
    logic [CAPACITY-1:0]       hit_reg, hit_next;
    op_t                       op_reg, op_next;
    logic [STAT_W-1:0]         st_reg, st_next;
    logic                      find_reg, find_next;
    logic signed [VALUE_W-1:0] val_reg;

    // Output payload
    logic [STAT_W-1:0]         status_reg, status_next;
    logic signed [VALUE_W-1:0] rdval_reg, rdval_next;
    logic [LEN_W-1:0]          len_reg, len_next;

    logic [IW-1:0]             cnt_w, idx_w;
    logic                      full, empty;
    logic [CAPACITY-1:0]       ge, eq;
    logic                      found, miss;
    op_t                       op_eff;
    logic [VALUE_W-1:0]        rd_sel;
    logic [CAPACITY-1:0]       col [VALUE_W];
    logic [LW-1:0]             len_wide;

    // Compare cycle: decide status and mark the target cell
    always_comb begin
        cnt_w     = IW'(count_reg);
        idx_w     = IW'(s_index);
        full      = (count_reg == CW'(CAPACITY));
        empty     = (count_reg == '0);
        hit_next  = '0;
        op_next   = OP_NONE;
        st_next   = STAT_OK;
        find_next = 1'b0;
        case (s_mode)
            MODE_APPEND: begin
                if (full) begin
                    st_next = STAT_FULL;
                end else begin
                    op_next = OP_INS;
                    for (int k = 0; k < CAPACITY; k++) begin
                        hit_next[k] = (IW'(k) == cnt_w);
                    end
                end
            end
            MODE_INSERT: begin
                if (idx_w > cnt_w) begin
                    st_next = STAT_RANGE;
                end else if (full) begin
                    st_next = STAT_FULL;
                end else begin
                    op_next = OP_INS;
                    for (int k = 0; k < CAPACITY; k++) begin
                        hit_next[k] = (IW'(k) == idx_w);
                    end
                end
            end
            MODE_READ, MODE_REMOVE: begin
                if (empty) begin
                    st_next = STAT_EMPTY;
                end else if (idx_w >= cnt_w) begin
                    st_next = STAT_RANGE;
                end else begin
                    op_next = (s_mode == MODE_READ) ? OP_READ : OP_DEL;
                    for (int k = 0; k < CAPACITY; k++) begin
                        hit_next[k] = (IW'(k) == idx_w);
                    end
                end
            end
            MODE_FIND: begin
                if (empty) begin
                    st_next = STAT_EMPTY;
                end else begin
                    op_next   = OP_DEL;
                    find_next = 1'b1;
                    for (int k = 0; k < CAPACITY; k++) begin
                        hit_next[k] = (cell_reg[k] == s_value) && (IW'(k) < cnt_w);
                    end
                end
            end
            MODE_HEAD: begin
                if (empty) begin
                    st_next = STAT_EMPTY;
                end else begin
                    op_next    = OP_DEL;
                    hit_next[0] = 1'b1;
                end
            end
            default: begin
                op_next = OP_NONE;
            end
        endcase
    end

    // Hold the compare results for the shift cycle
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            hit_reg  <= hit_next;
            op_reg   <= op_next;
            st_reg   <= st_next;
            find_reg <= find_next;
            val_reg  <= s_value;
        end
    end

    // Mark every cell at or past the first hit, then isolate the first hit
    always_comb begin
        ge = hit_reg;
        for (int s = 1; s < CAPACITY; s = s * 2) begin
            ge = ge | (ge << s);
        end
        eq = ge & ~(ge << 1);
    end

    // Select the target cell value, one bit column at a time
    always_comb begin
        for (int b = 0; b < VALUE_W; b++) begin
            for (int k = 0; k < CAPACITY; k++) begin
                col[b][k] = cell_reg[k][b];
            end
            rd_sel[b] = |(eq & col[b]);
        end
    end

    // Shift cycle: move cells, update count and load the result
    always_comb begin
        found  = |hit_reg;
        miss   = find_reg && !found;
        op_eff = miss ? OP_NONE : op_reg;
        for (int k = 0; k < CAPACITY; k++) begin
            cell_next[k] = cell_reg[k];
            case (op_eff)
                OP_INS: begin
                    if (eq[k]) begin
                        cell_next[k] = val_reg;
                    end else if (ge[k]) begin
                        cell_next[k] = cell_reg[(k > 0) ? k - 1 : 0];
                    end
                end
                OP_DEL: begin
                    if (ge[k]) begin
                        cell_next[k] = cell_reg[(k < CAPACITY - 1) ? k + 1 : k];
                    end
                end
                default: begin
                    cell_next[k] = cell_reg[k];
                end
            endcase
        end
        case (op_eff)
            OP_INS:  count_next = count_reg + CW'(1);
            OP_DEL:  count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
        status_next = miss ? STAT_NOTFOUND : st_reg;
        rdval_next  = (op_eff == OP_READ || op_eff == OP_DEL) ? $signed(rd_sel) : '0;
        len_wide    = LW'(count_next);
        len_next    = len_wide[LEN_W-1:0];
    end

    // Cell row holds its contents until written
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            for (int k = 0; k < CAPACITY; k++) begin
                cell_reg[k] <= cell_next[k];
            end
            status_reg <= status_next;
            rdval_reg  <= rdval_next;
            len_reg    <= len_next;
        end
    end

    // Fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.commit) begin
            count_reg <= count_next;
        end
    end

    assign m_status     = status_reg;
    assign m_read_value = rdval_reg;
    assign m_length     = len_reg;

endmodule

### hdl/ordered_list_engine.sv
// Ordered list engine: bounded list of signed 32-bit values held in a row of cells.
// Sequence: the compare results are registered when a command is accepted, and the
// shift cycle then moves the cells and loads the result; a new command is taken only
// after that shift, and a result left untaken holds the next shift.
// Reset: synchronous active-low aresetn empties the list and clears the output valid;
// cell contents are not cleared.
module ordered_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic        [ole_pkg::MODE_W-1:0]    s_mode,
    input  logic signed [ole_pkg::VALUE_W-1:0]   s_value,
    input  logic        [ole_pkg::IDX_W-1:0]     s_index,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic        [ole_pkg::STAT_W-1:0]    m_status,
    output logic signed [ole_pkg::VALUE_W-1:0]   m_read_value,
    output logic        [ole_pkg::LEN_W-1:0]     m_length
);
    import ole_pkg::*;

    ole_cmd_t cmd;

    // Sequencing
    ole_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Cell row, count and result register
    ole_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_mode       (s_mode),
        .s_value      (s_value),
        .s_index      (s_index),
        .m_status     (m_status),
        .m_read_value (m_read_value),
        .m_length     (m_length)
    );

endmodule

### hdl/ole_checker.sv
module ole_checker #(
    parameter int CAPACITY = 64
) (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic        [ole_pkg::STAT_W-1:0]    m_status,
    input logic signed [ole_pkg::VALUE_W-1:0]   m_read_value,
    input logic        [ole_pkg::LEN_W-1:0]     m_length
);
    import ole_pkg::*;

    localparam int CAPW = $clog2(CAPACITY + 1) + LEN_W;
    localparam logic [CAPW-1:0] CAP_W = CAPW'(CAPACITY);
    localparam logic [LEN_W-1:0] CAP_LEN = CAP_W[LEN_W-1:0];

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_read_value) && $stable(m_length))
        else $error("stalled result changed");

    // One command in flight: no accept right after an accept
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted twice in a row");

    // Failed commands return no value
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STAT_OK |-> m_read_value == '0)
        else $error("value returned on failed command");

    // Full status only at capacity
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_FULL |-> m_length == CAP_LEN)
        else $error("full reported below capacity");

endmodule

bind ordered_list_engine ole_checker #(
    .CAPACITY (CAPACITY)
) u_ole_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_read_value (m_read_value),
    .m_length     (m_length)
);

### test/tb.sv
`timescale 1ns / 1ps

module tb;
    import ole_pkg::*;

    localparam int DEPTH        = 64;
    localparam int RANDOM_ITEMS = 1030;
    localparam int STALL_LIMIT  = 200;
    localparam int DRAIN_CYCLES = 8;

    // Modes the block leaves unused
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    // Random phase flavors
    localparam int PH_GROW   = 0;
    localparam int PH_SHRINK = 1;
    localparam int PH_MIXED  = 2;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [VALUE_W-1:0] read_value;
        logic [LEN_W-1:0]          length;
    } list_result_t;

    // Mirror of the list contents plus the queue of results still owed
    class list_tracker;
        logic signed [VALUE_W-1:0] cells [DEPTH];
        int fill;
        list_result_t pending_results [$];
        int errors;
        int commands;
        int results;
        int full_hits;
        int empty_hits;
        int peak;

        function new();
            fill = 0;
            errors = 0;
            commands = 0;
            results = 0;
            full_hits = 0;
            empty_hits = 0;
            peak = 0;
        endfunction

        // Push later entries toward the tail and drop the value in
        function void open_slot(int pos, logic signed [VALUE_W-1:0] v);
            int k;
            for (k = fill; k > pos; k--)
                cells[k] = cells[k-1];
            cells[pos] = v;
            fill++;
            if (fill > peak)
                peak = fill;
        endfunction

        // Close the gap toward the head
        function void close_slot(int pos);
            int k;
            for (k = pos; k + 1 < fill; k++)
                cells[k] = cells[k+1];
            fill--;
        endfunction

        // Update the mirror for one accepted item and queue its result
        function void apply_command(logic [MODE_W-1:0] mode,
                                    logic signed [VALUE_W-1:0] value,
                                    logic [IDX_W-1:0] index);
            list_result_t r;
            int k;
            int hit;
            r.status = STAT_OK;
            r.read_value = '0;
            hit = -1;
            case (mode)
                MODE_APPEND: begin
                    if (fill >= DEPTH)
                        r.status = STAT_FULL;
                    else
                        open_slot(fill, value);
                end
                MODE_INSERT: begin
                    // range check wins over the full check
                    if (int'(index) > fill)
                        r.status = STAT_RANGE;
                    else if (fill >= DEPTH)
                        r.status = STAT_FULL;
                    else
                        open_slot(int'(index), value);
                end
                MODE_READ, MODE_REMOVE: begin
                    if (fill == 0) begin
                        r.status = STAT_EMPTY;
                    end else if (int'(index) >= fill) begin
                        r.status = STAT_RANGE;
                    end else begin
                        r.read_value = cells[index];
                        if (mode == MODE_REMOVE)
                            close_slot(int'(index));
                    end
                end
                MODE_FIND: begin
                    if (fill == 0) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        for (k = 0; k < fill && hit < 0; k++)
                            if (cells[k] == value)
                                hit = k;
                        if (hit >= 0) begin
                            r.read_value = cells[hit];
                            close_slot(hit);
                        end else begin
                            r.status = STAT_NOTFOUND;
                        end
                    end
                end
                MODE_HEAD: begin
                    if (fill == 0) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        r.read_value = cells[0];
                        close_slot(0);
                    end
                end
                default: ;
            endcase
            r.length = LEN_W'(fill);
            if (r.status == STAT_FULL)
                full_hits++;
            if (r.status == STAT_EMPTY)
                empty_hits++;
            commands++;
            pending_results.push_back(r);
        endfunction

        // Compare one accepted result with the oldest one owed
        function void check_result(logic [STAT_W-1:0] status,
                                   logic signed [VALUE_W-1:0] read_value,
                                   logic [LEN_W-1:0] length);
            list_result_t want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d read_value %0d length %0d",
                       status, read_value, length);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            results++;
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                errors++;
            end
            if (read_value !== want.read_value) begin
                $error("read_value: expected %0d, got %0d", want.read_value, read_value);
                errors++;
            end
            if (length !== want.length) begin
                $error("length: expected %0d, got %0d", want.length, length);
                errors++;
            end
        endfunction
    endclass

    logic                        aclk    = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [MODE_W-1:0]           s_mode  = '0;
    logic signed [VALUE_W-1:0]   s_value = '0;
    logic [IDX_W-1:0]            s_index = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [STAT_W-1:0]           m_status;
    logic signed [VALUE_W-1:0]   m_read_value;
    logic [LEN_W-1:0]            m_length;

    bit          no_gaps = 1'b0;
    int          random_count = 0;
    list_tracker mirror;

    ordered_list_engine #(
        .CAPACITY(DEPTH)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_value     (s_value),
        .s_index     (s_index),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_read_value(m_read_value),
        .m_length    (m_length)
    );

    always #1 aclk = ~aclk;

    // Send one item; call at a falling edge, returns at a falling edge
    task automatic send_command(input logic [MODE_W-1:0] mode,
                                input logic signed [VALUE_W-1:0] value,
                                input logic [IDX_W-1:0] index);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode  <= mode;
        s_value <= value;
        s_index <= index;
        do @(posedge aclk); while (!s_ready);
        mirror.apply_command(mode, value, index);
        @(negedge aclk);
    endtask

    // Draw one command biased by the phase flavor
    task automatic random_command(input int kind);
        int roll;
        int n;
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
        logic [IDX_W-1:0]          index;
        n = mirror.fill;
        roll = $urandom_range(0, 99);
        case (kind)
            PH_GROW: begin
                if (roll < 45)
                    mode = MODE_APPEND;
                else if (roll < 90)
                    mode = MODE_INSERT;
                else
                    mode = MODE_W'($urandom_range(2, 7));
            end
            PH_SHRINK: begin
                if (roll < 30)
                    mode = MODE_HEAD;
                else if (roll < 60)
                    mode = MODE_REMOVE;
                else if (roll < 85)
                    mode = MODE_FIND;
                else if (roll < 93)
                    mode = MODE_READ;
                else
                    mode = MODE_W'($urandom_range(0, 7));
            end
            default: mode = MODE_W'($urandom_range(0, 7));
        endcase

        // Favor positions around the current length
        roll = $urandom_range(0, 99);
        if (roll < 55)
            index = IDX_W'($urandom_range(0, n));
        else if (roll < 70)
            index = IDX_W'((n > 0) ? n - 1 : 0);
        else if (roll < 80)
            index = IDX_W'(n);
        else if (roll < 90)
            index = '0;
        else
            index = IDX_W'($urandom_range(0, 127));

        // Reuse stored values often so searches hit, small values for duplicates
        roll = $urandom_range(0, 99);
        if (roll < 40 && n > 0)
            value = mirror.cells[$urandom_range(0, n - 1)];
        else if (roll < 60)
            value = $signed(VALUE_W'($urandom_range(0, 6))) - 3;
        else if (roll < 68)
            value = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        else
            value = $urandom;

        random_count++;
        send_command(mode, value, index);
    endtask

    // Result side: random stalls, check every accepted result
    initial begin : result_sink
        int stall;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            mirror.check_result(m_status, m_read_value, m_length);
            @(negedge aclk);
        end
    end

    // End the run if neither channel moves an item for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                idle = 0;
            else
                idle++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int kind;
        int len;
        int j;
        int directed;
        mirror = new();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty list: every read or remove reports empty
        send_command(MODE_READ,   0, 0);
        send_command(MODE_REMOVE, 0, 0);
        send_command(MODE_FIND,   5, 0);
        send_command(MODE_HEAD,   0, 0);
        // Insert past the length, then at head and tail with extreme values
        send_command(MODE_INSERT, 3, 1);
        send_command(MODE_INSERT, 32'h7fff_ffff, 0);
        send_command(MODE_APPEND, 32'h8000_0000, 0);
        send_command(MODE_INSERT, 0, 2);
        send_command(MODE_INSERT, -1, 0);
        send_command(MODE_APPEND, -1, 127);
        send_command(MODE_INSERT, 9, 127);
        // Reads at the last entry and past it
        send_command(MODE_READ,   0, 4);
        send_command(MODE_READ,   0, 5);
        send_command(MODE_READ,   0, 127);
        // Search with a duplicate present, then a miss
        send_command(MODE_FIND,   -1, 0);
        send_command(MODE_FIND,   12345, 0);
        send_command(MODE_REMOVE, 0, 1);
        send_command(MODE_REMOVE, 0, 3);
        send_command(MODE_SPARE_LO, 32'h5555_aaaa, 64);
        send_command(MODE_SPARE_HI, 32'haaaa_5555, 127);
        // Drain through the head until empty
        send_command(MODE_HEAD,   0, 0);
        send_command(MODE_READ,   0, 0);
        send_command(MODE_HEAD,   0, 0);
        send_command(MODE_HEAD,   0, 0);
        directed = mirror.commands;

        // Random phases alternate growth to full, shrink to empty, and mixed traffic
        phase = 0;
        while (random_count < RANDOM_ITEMS) begin
            kind = phase % 3;
            no_gaps = (phase % 4 == 3);
            len = (kind == PH_MIXED) ? 70 : 140;
            for (j = 0; j < len && random_count < RANDOM_ITEMS; j++)
                random_command(kind);
            if (phase == 2) begin
                // hold the sender until every result is back
                s_valid <= 1'b0;
                @(negedge aclk);
                while (mirror.pending_results.size() != 0)
                    @(negedge aclk);
            end
            phase++;
        end

        // Wait out the remaining results
        s_valid <= 1'b0;
        @(negedge aclk);
        while (mirror.pending_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Sent %0d commands (%0d directed) and checked %0d results.",
                 mirror.commands, directed, mirror.results);
        $display("List full reported %0d times, empty %0d times, deepest fill %0d.",
                 mirror.full_hits, mirror.empty_hits, mirror.peak);
        if (mirror.errors == 0 && mirror.pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
